>>> hdl/lsm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the lidar scan leg masker.
// Holds the command and register codes, the state encoding and the sine table builder.
// No dependencies.
package lsm_pkg;

    localparam int SINE_DEPTH = 256;
    localparam int SINE_AW    = 8;
    localparam longint SIN_A  = 51472;
    localparam longint SIN_B  = 21023;
    localparam longint SIN_C  = 2320;
    localparam logic [31:0] LEG_MIN_D2 = 32'd62500;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_RAY   = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_OFFSET_X    = 3'd0,
        REG_OFFSET_Y    = 3'd1,
        REG_MASK_RADIUS = 3'd2,
        REG_RANGE_LOWER = 3'd3,
        REG_RANGE_UPPER = 3'd4,
        REG_ANGLE_START = 3'd5,
        REG_ANGLE_STEP  = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_SQ,
        ST_LD_CHK,
        ST_RAY_MUL,
        ST_RAY_ANG,
        ST_RAY_COS,
        ST_RAY_SIN,
        ST_RAY_PX,
        ST_RAY_PY,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef logic signed [15:0] sine_rom_t [SINE_DEPTH];

    function automatic logic signed [15:0] sine_entry(input int k);
        longint p;
        longint q;
        longint x;
        longint u;
        longint u2;
        longint t;
        p = (longint'(k) * (65536 / SINE_DEPTH)) & 64'hFFFF;
        q = p >> 14;
        x = (p & 64'h3FFF) << 1;
        u = ((q & 1) != 0) ? (32768 - x) : x;
        u2 = (u * u) >> 15;
        t = SIN_B - ((SIN_C * u2) >> 15);
        t = SIN_A - ((t * u2) >> 15);
        t = (t * u) >> 15;
        if (t > 32767)
        begin
            t = 32767;
        end
        if (q >= 2)
        begin
            t = -t;
        end
        return 16'(t);
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t r;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            r[k] = sine_entry(k);
        end
        return r;
    endfunction

endpackage

>>> hdl/lsm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/lidar_scan_leg_masker_unit.sv
`timescale 1ns / 1ps
// Top level of the lidar scan leg masker: command decode, leg table scan, ray geometry.
// Depends on lsm_pkg and lsm_ram.
//
// Usage
//   Input: a beat is taken at a rising edge with start high and busy low. command selects
//   clear table, load leg (leg_x, leg_y), process ray (ray_index, ray_range) or no-op.
//   Output: each ray gives one result beat on range_out and masked, marked by done for
//   exactly one cycle. The receiver cannot stall; results are never held back.
//   Config: cfg_we writes cfg_data into register cfg_index at a rising edge; write only
//   while busy is low.
// Sequencing (states from the accepting edge until busy falls)
//   clear, no-op: busy never rises
//   load: ST_LD_SQ, ST_LD_CHK
//   ray out of range limits: ST_OUT, done in that state
//   ray in limits: ST_RAY_MUL through ST_RAY_PY, ST_SCAN and ST_OUT, done in the last state; the
//   leg table RAM is read one entry per cycle through a three-stage distance pipeline.
//   The next beat is taken at the first edge with busy low.
// Reset
//   rst_n clears the leg count, the state machine and loads register defaults; the table
//   RAM is not cleared, entries beyond the count are never read.
module lidar_scan_leg_masker_unit
    import lsm_pkg::*;
#(
    parameter int MAX_LEGS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [15:0] leg_x,
    input  logic signed [15:0] leg_y,
    input  logic [11:0]        ray_index,
    input  logic [15:0]        ray_range,
    output logic               done,
    output logic [15:0]        range_out,
    output logic               masked,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;
    localparam int CW = $clog2(MAX_LEGS + 1);
    localparam sine_rom_t SINE_ROM = build_sine();

    state_t state_reg, state_next;

    logic signed [11:0] offset_x_reg, offset_y_reg;
    logic [11:0]        mask_radius_reg;
    logic [15:0]        range_lower_reg, range_upper_reg;
    logic [15:0]        angle_start_reg;
    logic [11:0]        angle_step_reg;

    logic [CW-1:0] leg_count_reg, leg_count_next;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic          rd_v_reg, rd_v_next;
    logic          d_v_reg, d_v_next;
    logic          sq_v_reg, sq_v_next;
    logic          hit_reg, hit_next;

    logic               ray_ok;
    logic [15:0]        rng_reg, rng_next;
    logic [11:0]        idx_reg, idx_next;
    logic signed [15:0] x_reg, x_next, y_reg, y_next;
    logic [31:0]        xx_reg, xx_next, yy_reg, yy_next, up2_reg, up2_next;
    logic [23:0]        r2_reg, r2_next;
    logic [23:0]        aprod_reg, aprod_next;
    logic [15:0]        ang_reg, ang_next;
    logic signed [15:0] trig_reg, trig_next;
    logic signed [32:0] pr_reg, pr_next;
    logic signed [17:0] px_reg, px_next, py_reg, py_next;
    logic signed [18:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [35:0]        dx2_reg, dx2_next, dy2_reg, dy2_next;

    logic signed [16:0] sum_x, sum_y;
    logic signed [15:0] sat_x, sat_y;
    logic [31:0]        d2;
    logic [15:0]        rom_ang;
    logic signed [32:0] pr_rnd;
    logic signed [17:0] rnd;
    logic signed [37:0] dx_full, dy_full;
    logic [36:0]        dist2;
    logic               issue, accept, scan_empty;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    lsm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_LEGS)
    ) u_leg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept = start && !busy;
    assign ray_ok = (ray_range >= range_lower_reg) && (ray_range <= range_upper_reg);
    assign issue  = (state_reg == ST_SCAN) && (rd_cnt_reg < leg_count_reg);
    assign scan_empty = !issue && !rd_v_reg && !d_v_reg && !sq_v_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_LOAD)
                begin
                    state_next = ST_LD_SQ;
                end
                else if (accept && command == CMD_RAY)
                begin
                    state_next = ray_ok ? ST_RAY_MUL : ST_OUT;
                end
            end
            ST_LD_SQ:   state_next = ST_LD_CHK;
            ST_LD_CHK:  state_next = ST_IDLE;
            ST_RAY_MUL: state_next = ST_RAY_ANG;
            ST_RAY_ANG: state_next = ST_RAY_COS;
            ST_RAY_COS: state_next = ST_RAY_SIN;
            ST_RAY_SIN: state_next = ST_RAY_PX;
            ST_RAY_PX:  state_next = ST_RAY_PY;
            ST_RAY_PY:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_empty)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        done      = (state_reg == ST_OUT);
        range_out = rng_reg;
        masked    = hit_reg;
    end

    // datapath
    always_comb
    begin
        sum_x = 17'(leg_x) + 17'(offset_x_reg);
        sum_y = 17'(leg_y) + 17'(offset_y_reg);
        if (sum_x > 17'sd32767)
        begin
            sat_x = 16'sh7FFF;
        end
        else if (sum_x < -17'sd32768)
        begin
            sat_x = -16'sh8000;
        end
        else
        begin
            sat_x = sum_x[15:0];
        end
        if (sum_y > 17'sd32767)
        begin
            sat_y = 16'sh7FFF;
        end
        else if (sum_y < -17'sd32768)
        begin
            sat_y = -16'sh8000;
        end
        else
        begin
            sat_y = sum_y[15:0];
        end

        d2      = xx_reg + yy_reg;
        rom_ang = (state_reg == ST_RAY_COS) ? ang_reg + QUARTER_TURN : ang_reg;
        pr_rnd  = pr_reg + (pr_reg[32] ? 33'sd16383 : 33'sd16384);
        rnd     = pr_rnd[32:15];
        dx_full = dx_reg * dx_reg;
        dy_full = dy_reg * dy_reg;
        dist2   = {1'b0, dx2_reg} + {1'b0, dy2_reg};

        leg_count_next = leg_count_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_v_next      = issue;
        d_v_next       = rd_v_reg;
        sq_v_next      = d_v_reg;
        hit_next       = hit_reg;
        rng_next       = rng_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        up2_next       = up2_reg;
        r2_next        = r2_reg;
        aprod_next     = aprod_reg;
        ang_next       = ang_reg;
        trig_next      = trig_reg;
        pr_next        = pr_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dx2_next       = dx2_reg;
        dy2_next       = dy2_reg;
        ram_we         = 1'b0;
        ram_waddr      = leg_count_reg[AW-1:0];
        ram_wdata      = {x_reg, y_reg};
        ram_raddr      = rd_cnt_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            leg_count_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            x_next = sat_x;
                            y_next = sat_y;
                        end
                        CMD_RAY:
                        begin
                            rng_next = ray_range;
                            idx_next = ray_index;
                            hit_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LD_SQ:
            begin
                xx_next  = 32'(x_reg * x_reg);
                yy_next  = 32'(y_reg * y_reg);
                up2_next = range_upper_reg * range_upper_reg;
            end
            ST_LD_CHK:
            begin
                if (leg_count_reg < CW'(MAX_LEGS) && d2 >= LEG_MIN_D2 && d2 <= up2_reg)
                begin
                    ram_we         = 1'b1;
                    leg_count_next = leg_count_reg + 1'b1;
                end
            end
            ST_RAY_MUL:
            begin
                aprod_next = angle_step_reg * idx_reg;
                r2_next    = mask_radius_reg * mask_radius_reg;
            end
            ST_RAY_ANG:
            begin
                ang_next = angle_start_reg + aprod_reg[15:0];
            end
            ST_RAY_COS:
            begin
                trig_next = SINE_ROM[rom_ang[15 -: SINE_AW]];
            end
            ST_RAY_SIN:
            begin
                pr_next   = $signed({1'b0, rng_reg}) * trig_reg;
                trig_next = SINE_ROM[rom_ang[15 -: SINE_AW]];
            end
            ST_RAY_PX:
            begin
                px_next = rnd + 18'(offset_x_reg);
                pr_next = $signed({1'b0, rng_reg}) * trig_reg;
            end
            ST_RAY_PY:
            begin
                py_next     = rnd + 18'(offset_y_reg);
                rd_cnt_next = '0;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (rd_v_reg)
                begin
                    dx_next = 19'(px_reg) - 19'($signed(ram_rdata[31:16]));
                    dy_next = 19'(py_reg) - 19'($signed(ram_rdata[15:0]));
                end
                if (d_v_reg)
                begin
                    dx2_next = dx_full[35:0];
                    dy2_next = dy_full[35:0];
                end
                if (sq_v_reg && dist2 <= 37'(r2_reg))
                begin
                    hit_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            leg_count_reg   <= '0;
            rd_cnt_reg      <= '0;
            rd_v_reg        <= 1'b0;
            d_v_reg         <= 1'b0;
            sq_v_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            offset_x_reg    <= 12'sd200;
            offset_y_reg    <= 12'sd0;
            mask_radius_reg <= 12'd800;
            range_lower_reg <= 16'd0;
            range_upper_reg <= 16'd30000;
            angle_start_reg <= 16'h8000;
            angle_step_reg  <= 12'd16;
        end
        else
        begin
            state_reg     <= state_next;
            leg_count_reg <= leg_count_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_v_reg      <= rd_v_next;
            d_v_reg       <= d_v_next;
            sq_v_reg      <= sq_v_next;
            hit_reg       <= hit_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_OFFSET_X:    offset_x_reg    <= cfg_data[11:0];
                    REG_OFFSET_Y:    offset_y_reg    <= cfg_data[11:0];
                    REG_MASK_RADIUS: mask_radius_reg <= cfg_data[11:0];
                    REG_RANGE_LOWER: range_lower_reg <= cfg_data;
                    REG_RANGE_UPPER: range_upper_reg <= cfg_data;
                    REG_ANGLE_START: angle_start_reg <= cfg_data;
                    REG_ANGLE_STEP:  angle_step_reg  <= cfg_data[11:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rng_reg   <= rng_next;
        idx_reg   <= idx_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        xx_reg    <= xx_next;
        yy_reg    <= yy_next;
        up2_reg   <= up2_next;
        r2_reg    <= r2_next;
        aprod_reg <= aprod_next;
        ang_reg   <= ang_next;
        trig_reg  <= trig_next;
        pr_reg    <= pr_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dx2_reg   <= dx2_next;
        dy2_reg   <= dy2_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        leg_count_reg <= CW'(MAX_LEGS))
        else $error("leg count beyond table depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (leg_count_reg < CW'(MAX_LEGS)) && (state_reg == ST_LD_CHK))
        else $error("leg table write without room");

    a_ray_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_RAY) |=> busy)
        else $error("ray beat accepted but block not busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

endmodule
